// ===== src/modbus_tcp_register_slave_core_assert.svh =====
// Assertion macros for the modbus TCP slave RTL, used by mbtcp_engine.
`ifndef MODBUS_TCP_REGISTER_SLAVE_CORE_ASSERT_SVH
`define MODBUS_TCP_REGISTER_SLAVE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define MBTCP_ASSERT_IMP(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MBTCP_ASSERT_NXT(label, clock, reset, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mbtcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbtcp_pkg;

  localparam int unsigned MAX_REGS_PER_REQUEST = 125;
  localparam int unsigned FRAME_BYTES          = 256;

  localparam int unsigned MAP_WORDS = 38;
  localparam int unsigned MAP_IDX_W = $clog2(MAP_WORDS);
  localparam logic [MAP_IDX_W-1:0] MAP_WORDS_IDX  = MAP_IDX_W'(MAP_WORDS);
  localparam logic [15:0]          MAP_WORDS_ADDR = 16'(MAP_WORDS);

  localparam logic [15:0] ADDR_COUNTER      = 16'd1;
  localparam logic [15:0] ADDR_SYSTEM_STATE = 16'd38;
  localparam logic [15:0] ADDR_AUX_PARAM    = 16'd39;

  localparam logic OP_RECEIVE = 1'b0;
  localparam logic OP_PULL    = 1'b1;

  localparam logic [7:0] FC_READ_HOLDING    = 8'h03;
  localparam logic [7:0] FC_READ_INPUT      = 8'h04;
  localparam logic [7:0] FC_WRITE_SINGLE    = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTIPLE  = 8'h10;
  localparam logic [7:0] FC_READ_WRITE      = 8'h17;
  localparam logic [7:0] FC_EXCEPTION_BIT   = 8'h80;
  localparam logic [7:0] EXC_ILLEGAL_VALUE  = 8'h03;

  typedef struct packed {
    logic        operation;
    logic [7:0]  rx_byte;
    logic [15:0] system_state;
    logic [15:0] aux_param_value;
  } req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
  } rsp_t;

  typedef struct packed {
    logic                 en;
    logic [MAP_IDX_W-1:0] idx;
    logic [15:0]          data;
  } mem_wr_t;

endpackage

`default_nettype wire

// ===== src/mbtcp_regmem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbtcp_regmem (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire mbtcp_pkg::mem_wr_t               wr,
  input  wire logic [mbtcp_pkg::MAP_IDX_W-1:0]  rd_idx,
  output logic [15:0]                           rd_data
);

  logic [15:0]                       mem [0:mbtcp_pkg::MAP_WORDS-1];
  logic [mbtcp_pkg::MAP_WORDS-1:0]   written;
  logic [15:0]                       rd_q;
  logic                              rd_written;
  logic                              rd_in_map;

  assign rd_in_map = (rd_idx < mbtcp_pkg::MAP_WORDS_IDX);

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.data;
    end
    if (rd_in_map) begin
      rd_q <= mem[rd_idx];
    end
  end

  // A word never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.idx] <= 1'b1;
      end
      rd_written <= rd_in_map ? written[rd_idx] : 1'b0;
    end
  end

  assign rd_data = rd_written ? rd_q : 16'h0000;

endmodule

`default_nettype wire

// ===== src/mbtcp_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "modbus_tcp_register_slave_core_assert.svh"

module mbtcp_engine (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             item_valid,
  input  wire mbtcp_pkg::req_t                  item,
  input  wire logic                             step,
  output logic                                  res_valid,
  output mbtcp_pkg::rsp_t                       res,
  output mbtcp_pkg::mem_wr_t                    mem_wr,
  output logic [mbtcp_pkg::MAP_IDX_W-1:0]       mem_rd_idx,
  input  wire logic [15:0]                      mem_rd_data
);

  function automatic logic count_bad(input logic [15:0] n);
    return (n == 16'h0000) || (n > 16'(mbtcp_pkg::MAX_REGS_PER_REQUEST));
  endfunction

  // Frame and response state.
  logic [15:0] access_counter,   access_counter_next;
  logic [15:0] transaction_id,   transaction_id_next;
  logic [15:0] protocol_id,      protocol_id_next;
  logic [15:0] pdu_length,       pdu_length_next;
  logic [7:0]  unit_id,          unit_id_next;
  logic [7:0]  function_code,    function_code_next;
  logic [16:0] byte_position,    byte_position_next;
  logic [15:0] start_addr,       start_addr_next;
  logic [15:0] count_val,        count_val_next;
  logic [15:0] wr_start,         wr_start_next;
  logic [15:0] wr_count,         wr_count_next;
  logic [15:0] byte_count,       byte_count_next;
  logic [7:0]  data_high_hold,   data_high_hold_next;
  logic [8:0]  response_position, response_position_next;
  logic        response_pending, response_pending_next;
  logic        exception_flag,   exception_flag_next;
  logic        frame_ok,         frame_ok_next;
  logic [15:0] rd_addr,          rd_addr_next;

  // Working values.
  logic        frame_start;
  logic [15:0] start_c, count_c, wr_start_c, wr_count_c, byte_count_c;
  logic        ok_c, exc_c;
  logic [7:0]  fc_c, unit_c, b;
  logic [16:0] q, d, pos_inc, pdu_end;
  logic [15:0] base;
  logic        do_shift, do_take;
  logic        wr_any;
  logic [15:0] wr_addr, wr_data;
  logic        read_resp;
  logic [9:0]  resp_len, mbap_len, total_len, r_inc;
  logic [8:0]  r_hdr, r_dat, rd_rel;
  logic [15:0] pair_word, rd_word;
  logic [7:0]  tx_val;
  logic        is_last;
  logic        pull_active;

  assign b           = item.rx_byte;
  assign frame_start = (byte_position == 17'd0);
  assign read_resp   = !exception_flag && (function_code != mbtcp_pkg::FC_WRITE_SINGLE)
                       && (function_code != mbtcp_pkg::FC_WRITE_MULTIPLE);
  assign pull_active = item_valid && (item.operation == mbtcp_pkg::OP_PULL)
                       && response_pending;

  // The first byte of a frame sees the request fields already cleared.
  assign start_c      = frame_start ? 16'h0000 : start_addr;
  assign count_c      = frame_start ? 16'h0000 : count_val;
  assign wr_start_c   = frame_start ? 16'h0000 : wr_start;
  assign wr_count_c   = frame_start ? 16'h0000 : wr_count;
  assign byte_count_c = frame_start ? 16'h0000 : byte_count;
  assign ok_c         = frame_start ? 1'b1 : frame_ok;
  assign exc_c        = frame_start ? 1'b0 : exception_flag;
  assign fc_c         = frame_start ? 8'h00 : function_code;
  assign unit_c       = frame_start ? 8'h00 : unit_id;

  // Word selected by the registered read address.
  always_comb begin
    priority if (rd_addr == mbtcp_pkg::ADDR_COUNTER) begin
      rd_word = access_counter + 16'd1;
    end else if (rd_addr < mbtcp_pkg::MAP_WORDS_ADDR) begin
      rd_word = mem_rd_data;
    end else if (rd_addr == mbtcp_pkg::ADDR_SYSTEM_STATE) begin
      rd_word = item.system_state;
    end else if (rd_addr == mbtcp_pkg::ADDR_AUX_PARAM) begin
      rd_word = item.aux_param_value;
    end else begin
      rd_word = 16'h0000;
    end
  end

  // Response byte for the current position.
  always_comb begin
    if (exception_flag) begin
      resp_len = 10'd2;
    end else if (!read_resp) begin
      resp_len = 10'd5;
    end else begin
      resp_len = 10'd2 + {1'b0, count_val[7:0], 1'b0};
    end
    mbap_len  = resp_len + 10'd1;
    total_len = resp_len + 10'd7;
    r_inc     = {1'b0, response_position} + 10'd1;
    is_last   = (r_inc >= total_len);
    r_hdr     = response_position - 9'd8;
    r_dat     = response_position - 9'd9;
    pair_word = r_hdr[1] ? count_val : start_addr;

    priority if (response_position == 9'd0) begin
      tx_val = transaction_id[15:8];
    end else if (response_position == 9'd1) begin
      tx_val = transaction_id[7:0];
    end else if (response_position == 9'd2) begin
      tx_val = protocol_id[15:8];
    end else if (response_position == 9'd3) begin
      tx_val = protocol_id[7:0];
    end else if (response_position == 9'd4) begin
      tx_val = {6'b000000, mbap_len[9:8]};
    end else if (response_position == 9'd5) begin
      tx_val = mbap_len[7:0];
    end else if (response_position == 9'd6) begin
      tx_val = unit_id;
    end else if (response_position == 9'd7) begin
      tx_val = exception_flag ? (function_code | mbtcp_pkg::FC_EXCEPTION_BIT)
                              : function_code;
    end else if (exception_flag) begin
      tx_val = mbtcp_pkg::EXC_ILLEGAL_VALUE;
    end else if (!read_resp) begin
      tx_val = r_hdr[0] ? pair_word[7:0] : pair_word[15:8];
    end else if (response_position == 9'd8) begin
      tx_val = {count_val[6:0], 1'b0};
    end else if (!r_dat[0]) begin
      tx_val = rd_word[15:8];
    end else begin
      tx_val = data_high_hold;
    end

    res_valid     = pull_active;
    res.tx_byte   = tx_val;
    res.last_byte = is_last;
  end

  always_comb begin
    access_counter_next    = access_counter;
    transaction_id_next    = transaction_id;
    protocol_id_next       = protocol_id;
    pdu_length_next        = pdu_length;
    unit_id_next           = unit_id;
    function_code_next     = function_code;
    byte_position_next     = byte_position;
    start_addr_next        = start_addr;
    count_val_next         = count_val;
    wr_start_next          = wr_start;
    wr_count_next          = wr_count;
    byte_count_next        = byte_count;
    data_high_hold_next    = data_high_hold;
    response_position_next = response_position;
    response_pending_next  = response_pending;
    exception_flag_next    = exception_flag;
    frame_ok_next          = frame_ok;
    q        = byte_position - 17'd8;
    d        = 17'd0;
    base     = 16'h0000;
    do_shift = 1'b0;
    do_take  = 1'b0;
    wr_any   = 1'b0;
    wr_addr  = 16'h0000;
    wr_data  = 16'h0000;
    pos_inc  = byte_position + 17'd1;
    pdu_end  = 17'd0;

    if (step && (item.operation == mbtcp_pkg::OP_RECEIVE)) begin
      // A received byte drops whatever is left of a pending response.
      response_pending_next = 1'b0;
      start_addr_next       = start_c;
      count_val_next        = count_c;
      wr_start_next         = wr_start_c;
      wr_count_next         = wr_count_c;
      byte_count_next       = byte_count_c;
      frame_ok_next         = ok_c;
      exception_flag_next   = exc_c;
      function_code_next    = fc_c;
      unit_id_next          = unit_c;

      if (byte_position < 17'd6) begin
        unique case (byte_position[2:0])
          3'd0: transaction_id_next = {b, 8'h00};
          3'd1: transaction_id_next = transaction_id | {8'h00, b};
          3'd2: protocol_id_next    = {b, 8'h00};
          3'd3: protocol_id_next    = protocol_id | {8'h00, b};
          3'd4: pdu_length_next     = {b, 8'h00};
          default: begin
            pdu_length_next = pdu_length | {8'h00, b};
            if ((protocol_id != 16'h0000) ||
                (({1'b0, pdu_length_next} + 17'd6) > 17'(mbtcp_pkg::FRAME_BYTES))) begin
              frame_ok_next = 1'b0;
            end
          end
        endcase
      end else if (byte_position == 17'd6) begin
        unit_id_next = b;
      end else if (byte_position == 17'd7) begin
        function_code_next = b;
        priority if ((b == mbtcp_pkg::FC_READ_HOLDING) || (b == mbtcp_pkg::FC_READ_INPUT) ||
                     (b == mbtcp_pkg::FC_WRITE_SINGLE)) begin
          if (pdu_length < 16'd6) frame_ok_next = 1'b0;
        end else if (b == mbtcp_pkg::FC_WRITE_MULTIPLE) begin
          if (pdu_length < 16'd7) frame_ok_next = 1'b0;
        end else if (b == mbtcp_pkg::FC_READ_WRITE) begin
          if (pdu_length < 16'd11) frame_ok_next = 1'b0;
        end else begin
          frame_ok_next = 1'b0;
        end
      end else if (ok_c) begin
        unique case (fc_c)
          mbtcp_pkg::FC_READ_HOLDING, mbtcp_pkg::FC_READ_INPUT,
          mbtcp_pkg::FC_WRITE_SINGLE: begin
            do_shift = (q < 17'd4);
            if (q == 17'd3) begin
              if (fc_c == mbtcp_pkg::FC_WRITE_SINGLE) begin
                wr_any  = 1'b1;
                wr_addr = start_c;
                wr_data = {count_c[7:0], b};
              end else begin
                exception_flag_next = count_bad({count_c[7:0], b});
              end
            end
          end
          mbtcp_pkg::FC_WRITE_MULTIPLE: begin
            if (q < 17'd4) begin
              do_shift = 1'b1;
            end else if (q == 17'd4) begin
              byte_count_next = {8'h00, b};
              if (count_bad(count_c) || ({9'h000, b} != {count_c, 1'b0})) begin
                exception_flag_next = 1'b1;
              end else if (pdu_length < (16'd7 + {8'h00, b})) begin
                frame_ok_next = 1'b0;
              end
            end else begin
              do_take = 1'b1;
              d       = q - 17'd5;
              base    = start_c;
            end
          end
          mbtcp_pkg::FC_READ_WRITE: begin
            if (q < 17'd8) begin
              do_shift = 1'b1;
            end else if (q == 17'd8) begin
              byte_count_next = {8'h00, b};
              if (count_bad(count_c) || count_bad(wr_count_c) ||
                  ({9'h000, b} != {wr_count_c, 1'b0})) begin
                exception_flag_next = 1'b1;
              end else if (pdu_length < (16'd11 + {8'h00, b})) begin
                frame_ok_next = 1'b0;
              end
            end else begin
              do_take = 1'b1;
              d       = q - 17'd9;
              base    = wr_start_c;
            end
          end
          default: ;
        endcase
      end

      // Header fields of the request come in big-endian, two bytes each.
      if (do_shift) begin
        unique case (q[2:1])
          2'd0: start_addr_next = {start_c[7:0], b};
          2'd1: count_val_next  = {count_c[7:0], b};
          2'd2: wr_start_next   = {wr_start_c[7:0], b};
          2'd3: wr_count_next   = {wr_count_c[7:0], b};
        endcase
      end

      if (do_take && !exc_c && (d < {1'b0, byte_count_c})) begin
        if (!d[0]) begin
          data_high_hold_next = b;
        end else begin
          wr_any  = 1'b1;
          wr_addr = base + {9'h000, d[7:1]};
          wr_data = {data_high_hold, b};
        end
      end

      if (wr_any) begin
        access_counter_next = access_counter + 16'd1;
      end

      pdu_end = {1'b0, pdu_length_next} + 17'd6;
      if ((pos_inc >= 17'd6) && (pos_inc == pdu_end)) begin
        if (frame_ok_next && (pdu_length_next >= 16'd2)) begin
          response_pending_next  = 1'b1;
          response_position_next = 9'd0;
        end
        byte_position_next = 17'd0;
      end else begin
        byte_position_next = pos_inc;
      end
    end else if (step && pull_active) begin
      // The high byte of each read value fetches the word and holds its low byte.
      if (read_resp && (response_position > 9'd8) && !r_dat[0]) begin
        access_counter_next = access_counter + 16'd1;
        data_high_hold_next = rd_word[7:0];
      end
      if (is_last) begin
        response_pending_next  = 1'b0;
        response_position_next = 9'd0;
      end else begin
        response_position_next = r_inc[8:0];
      end
    end

    // Address for the next pull, known once this beat's state is settled.
    rd_rel       = response_position_next - 9'd9;
    rd_addr_next = start_addr_next + {8'h00, rd_rel[8:1]};
  end

  assign mem_wr.en   = wr_any && (wr_addr < mbtcp_pkg::MAP_WORDS_ADDR);
  assign mem_wr.idx  = wr_addr[mbtcp_pkg::MAP_IDX_W-1:0];
  assign mem_wr.data = wr_data;
  assign mem_rd_idx  = rd_addr_next[mbtcp_pkg::MAP_IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      access_counter    <= 16'h0000;
      transaction_id    <= 16'h0000;
      protocol_id       <= 16'h0000;
      pdu_length        <= 16'h0000;
      unit_id           <= 8'h00;
      function_code     <= 8'h00;
      byte_position     <= 17'd0;
      start_addr        <= 16'h0000;
      count_val         <= 16'h0000;
      wr_start          <= 16'h0000;
      wr_count          <= 16'h0000;
      byte_count        <= 16'h0000;
      data_high_hold    <= 8'h00;
      response_position <= 9'd0;
      response_pending  <= 1'b0;
      exception_flag    <= 1'b0;
      frame_ok          <= 1'b0;
    end else begin
      access_counter    <= access_counter_next;
      transaction_id    <= transaction_id_next;
      protocol_id       <= protocol_id_next;
      pdu_length        <= pdu_length_next;
      unit_id           <= unit_id_next;
      function_code     <= function_code_next;
      byte_position     <= byte_position_next;
      start_addr        <= start_addr_next;
      count_val         <= count_val_next;
      wr_start          <= wr_start_next;
      wr_count          <= wr_count_next;
      byte_count        <= byte_count_next;
      data_high_hold    <= data_high_hold_next;
      response_position <= response_position_next;
      response_pending  <= response_pending_next;
      exception_flag    <= exception_flag_next;
      frame_ok          <= frame_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= rd_addr_next;
  end

  `MBTCP_ASSERT_IMP(a_pending_frame_ok, clk, rst, response_pending, frame_ok, "response pending on a rejected frame")
  `MBTCP_ASSERT_IMP(a_read_count_legal, clk, rst, response_pending && read_resp, !count_bad(count_val), "read response with illegal count")
  `MBTCP_ASSERT_IMP(a_write_on_receive, clk, rst, mem_wr.en, step && (item.operation == mbtcp_pkg::OP_RECEIVE), "register write outside a receive beat")
  `MBTCP_ASSERT_NXT(a_last_ends_resp, clk, rst, step && res_valid && res.last_byte, !response_pending, "response still pending after its last byte")

endmodule

`default_nettype wire

// ===== src/modbus_tcp_register_slave_core.sv =====
// A pull beat is first registered in the input stage, then its byte in the output register.
// Throughput: one beat per cycle, receive or pull, unless the response side stalls a pull beat.
// Back-pressure on the response side stalls the input stage only when it holds a pull result.
// Reset (synchronous, active high) clears all frame and response state and the access
// counter; the register map reads zero until each word is written, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module modbus_tcp_register_slave_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire mbtcp_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output mbtcp_pkg::rsp_t      rsp
);

  logic                                 s1_valid;
  mbtcp_pkg::req_t                      s1_item;
  logic                                 s1_go;
  logic                                 step;
  logic                                 eng_res_valid;
  mbtcp_pkg::rsp_t                      eng_res;
  mbtcp_pkg::mem_wr_t                   mem_wr;
  logic [mbtcp_pkg::MAP_IDX_W-1:0]      mem_rd_idx;
  logic [15:0]                          mem_rd_data;

  // The held beat moves on unless it carries a result and the output register is full and not taken.
  assign s1_go     = !eng_res_valid || !rsp_valid || rsp_ready;
  assign step      = s1_valid && s1_go;
  assign req_ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_ready) begin
      s1_item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= (step && eng_res_valid) || (rsp_valid && !rsp_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (step && eng_res_valid) begin
      rsp <= eng_res;
    end
  end

  mbtcp_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (s1_valid),
    .item        (s1_item),
    .step        (step),
    .res_valid   (eng_res_valid),
    .res         (eng_res),
    .mem_wr      (mem_wr),
    .mem_rd_idx  (mem_rd_idx),
    .mem_rd_data (mem_rd_data)
  );

  mbtcp_regmem u_regmem (
    .clk     (clk),
    .rst     (rst),
    .wr      (mem_wr),
    .rd_idx  (mem_rd_idx),
    .rd_data (mem_rd_data)
  );

endmodule

`default_nettype wire

// ===== dv/mbtcp_frame_checker.sv =====
`timescale 1ns / 1ps

module mbtcp_frame_checker
  import mbtcp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  input  wire logic req_ready,
  input  wire req_t req,
  input  wire logic rsp_valid,
  input  wire logic rsp_ready,
  input  wire rsp_t rsp,
  output int        errors,
  output int        outstanding
);

  logic [15:0] map_words [MAP_WORDS];
  logic [15:0] access_count;
  logic [15:0] trans_id;
  logic [15:0] proto_id;
  logic [15:0] pdu_len;
  logic [7:0]  unit_addr;
  logic [7:0]  func;
  logic [7:0]  byte_hold;
  int unsigned rx_pos;
  logic [15:0] fields [5];
  logic [8:0]  tx_pos;
  logic        tx_pending;
  logic        exc_pending;
  logic        frame_good;
  rsp_t        tx_due [$];
  int          mismatches = 0;

  function automatic logic count_out_of_range(logic [15:0] n);
    return n == 16'd0 || n > 16'(MAX_REGS_PER_REQUEST);
  endfunction

  // Every access, read or write, bumps the counter; address 1 sees the new value.
  function automatic logic [15:0] map_read(logic [15:0] addr, logic [15:0] sys,
                                           logic [15:0] aux);
    access_count = access_count + 16'd1;
    if (addr == ADDR_COUNTER) return access_count;
    if (addr < MAP_WORDS_ADDR) return map_words[addr];
    if (addr == ADDR_SYSTEM_STATE) return sys;
    if (addr == ADDR_AUX_PARAM) return aux;
    return 16'd0;
  endfunction

  function automatic void map_write(logic [15:0] addr, logic [15:0] value);
    access_count = access_count + 16'd1;
    if (addr < MAP_WORDS_ADDR) map_words[addr] = value;
  endfunction

  function automatic void shift_in(int unsigned q, logic [7:0] b);
    int unsigned k;
    k = (q >> 1) & 3;
    fields[k] = {fields[k][7:0], b};
  endfunction

  function automatic void take_data(int unsigned d, logic [7:0] b, logic [15:0] base);
    if (exc_pending || d >= 32'(fields[4])) return;
    if (d[0] == 1'b0) byte_hold = b;
    else map_write(base + 16'(d >> 1), {byte_hold, b});
  endfunction

  function automatic void absorb_rx_byte(logic [7:0] b);
    int unsigned pos;
    int unsigned q;
    pos = rx_pos;
    tx_pending = 1'b0;
    if (pos == 0) begin
      foreach (fields[i]) fields[i] = '0;
      frame_good = 1'b1;
      exc_pending = 1'b0;
      func = '0;
      unit_addr = '0;
    end
    if (pos < 6) begin
      case (pos)
        0: trans_id = {b, 8'h00};
        1: trans_id[7:0] = b;
        2: proto_id = {b, 8'h00};
        3: proto_id[7:0] = b;
        4: pdu_len = {b, 8'h00};
        default: begin
          pdu_len[7:0] = b;
          if (proto_id != 16'd0 || 32'd6 + pdu_len > FRAME_BYTES) frame_good = 1'b0;
        end
      endcase
    end else if (pos == 6) begin
      unit_addr = b;
    end else if (pos == 7) begin
      func = b;
      if (b == FC_READ_HOLDING || b == FC_READ_INPUT || b == FC_WRITE_SINGLE) begin
        if (pdu_len < 16'd6) frame_good = 1'b0;
      end else if (b == FC_WRITE_MULTIPLE) begin
        if (pdu_len < 16'd7) frame_good = 1'b0;
      end else if (b == FC_READ_WRITE) begin
        if (pdu_len < 16'd11) frame_good = 1'b0;
      end else begin
        frame_good = 1'b0;
      end
    end else if (frame_good) begin
      q = pos - 8;
      if (func == FC_READ_HOLDING || func == FC_READ_INPUT || func == FC_WRITE_SINGLE) begin
        if (q < 4) shift_in(q, b);
        if (q == 3) begin
          if (func == FC_WRITE_SINGLE) map_write(fields[0], fields[1]);
          else exc_pending = count_out_of_range(fields[1]);
        end
      end else if (func == FC_WRITE_MULTIPLE) begin
        if (q < 4) begin
          shift_in(q, b);
        end else if (q == 4) begin
          fields[4] = {8'h00, b};
          if (count_out_of_range(fields[1]) || 32'(b) != 32'(fields[1]) * 2)
            exc_pending = 1'b1;
          else if (32'(pdu_len) < 32'd7 + b)
            frame_good = 1'b0;
        end else begin
          take_data(q - 5, b, fields[0]);
        end
      end else begin
        if (q < 8) begin
          shift_in(q, b);
        end else if (q == 8) begin
          fields[4] = {8'h00, b};
          if (count_out_of_range(fields[1]) || count_out_of_range(fields[3]) ||
              32'(b) != 32'(fields[3]) * 2)
            exc_pending = 1'b1;
          else if (32'(pdu_len) < 32'd11 + b)
            frame_good = 1'b0;
        end else begin
          take_data(q - 9, b, fields[2]);
        end
      end
    end
    pos++;
    if (pos >= 6 && pos == 32'd6 + pdu_len) begin
      if (frame_good && pdu_len >= 16'd2) begin
        tx_pending = 1'b1;
        tx_pos = '0;
      end
      rx_pos = 0;
    end else begin
      rx_pos = pos;
    end
  endfunction

  // Register values are fetched when the high byte of each word goes out.
  function automatic bit next_tx_byte(input logic [15:0] sys, input logic [15:0] aux,
                                      output rsp_t beat);
    int unsigned resp_len;
    int unsigned total;
    int unsigned r;
    int unsigned k;
    int unsigned j;
    logic [15:0] f;
    logic [15:0] w;
    logic [7:0]  v;
    beat = '0;
    if (!tx_pending) return 1'b0;
    if (exc_pending) resp_len = 2;
    else if (func == FC_WRITE_SINGLE || func == FC_WRITE_MULTIPLE) resp_len = 5;
    else resp_len = 2 + 2 * 32'(fields[1]);
    total = 7 + resp_len;
    r = 32'(tx_pos);
    if (r == 0) v = trans_id[15:8];
    else if (r == 1) v = trans_id[7:0];
    else if (r == 2) v = proto_id[15:8];
    else if (r == 3) v = proto_id[7:0];
    else if (r == 4) v = 8'((resp_len + 1) >> 8);
    else if (r == 5) v = 8'(resp_len + 1);
    else if (r == 6) v = unit_addr;
    else if (r == 7) v = exc_pending ? (func | FC_EXCEPTION_BIT) : func;
    else if (exc_pending) v = EXC_ILLEGAL_VALUE;
    else if (func == FC_WRITE_SINGLE || func == FC_WRITE_MULTIPLE) begin
      k = r - 8;
      f = fields[(k >> 1) & 1];
      v = k[0] ? f[7:0] : f[15:8];
    end else if (r == 8) begin
      v = 8'(2 * 32'(fields[1]));
    end else begin
      j = r - 9;
      if (j[0] == 1'b0) begin
        w = map_read(fields[0] + 16'(j >> 1), sys, aux);
        byte_hold = w[7:0];
        v = w[15:8];
      end else begin
        v = byte_hold;
      end
    end
    beat.tx_byte = v;
    beat.last_byte = (r + 1 >= total);
    if (r + 1 >= total) begin
      tx_pending = 1'b0;
      tx_pos = '0;
    end else begin
      tx_pos = 9'(r + 1);
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    rsp_t beat;
    rsp_t want;
    if (rst) begin
      foreach (map_words[i]) map_words[i] = '0;
      foreach (fields[i]) fields[i] = '0;
      access_count = '0;
      trans_id = '0;
      proto_id = '0;
      pdu_len = '0;
      unit_addr = '0;
      func = '0;
      byte_hold = '0;
      rx_pos = 0;
      tx_pos = '0;
      tx_pending = 1'b0;
      exc_pending = 1'b0;
      frame_good = 1'b0;
      tx_due.delete();
    end else begin
      // Output beats belong to earlier pulls, so they are matched before the new input.
      if (rsp_valid && rsp_ready) begin
        if (tx_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response beat tx_byte=%02h last_byte=%0b",
                   $time, rsp.tx_byte, rsp.last_byte);
        end else begin
          want = tx_due.pop_front();
          if (rsp.tx_byte !== want.tx_byte) begin
            mismatches++;
            $display("%0t: tx_byte expected %02h actual %02h",
                     $time, want.tx_byte, rsp.tx_byte);
          end
          if (rsp.last_byte !== want.last_byte) begin
            mismatches++;
            $display("%0t: last_byte expected %0b actual %0b",
                     $time, want.last_byte, rsp.last_byte);
          end
        end
      end
      if (req_valid && req_ready) begin
        if (req.operation == OP_RECEIVE) absorb_rx_byte(req.rx_byte);
        else if (next_tx_byte(req.system_state, req.aux_param_value, beat))
          tx_due.push_back(beat);
      end
    end
    errors <= mismatches;
    outstanding <= tx_due.size();
  end

endmodule

// ===== dv/tb_modbus_tcp_register_slave_core.sv =====
`timescale 1ns / 1ps

module tb_modbus_tcp_register_slave_core;
  import mbtcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned RANDOM_BEATS = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;
  int   errors;
  int   outstanding;

  // Frame under construction: unit id, function code and data.
  logic [7:0]  body [$];
  logic [15:0] frame_pid = 16'd0;
  int          len_override = -1;
  int          trim = 0;
  bit          no_idle = 1'b0;
  int unsigned sent_beats = 0;
  int unsigned cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  modbus_tcp_register_slave_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  mbtcp_frame_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .errors      (errors),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_beat(input logic op, input logic [7:0] data, input bit counts);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= '{operation: op, rx_byte: data, system_state: 16'($urandom),
             aux_param_value: 16'($urandom)};
    do @(posedge clk); while (!req_ready);
    if (counts) sent_beats++;
  endtask

  // Sends the MBAP header and the body, padded or cut to the length field, then pulls.
  task automatic send_frame(input int n_pull);
    logic [15:0] tid;
    logic [15:0] len;
    logic [47:0] hdr;
    tid = 16'($urandom);
    len = (len_override >= 0) ? 16'(len_override) : 16'(body.size() - trim);
    hdr = {tid, frame_pid, len};
    for (int i = 0; i < 6; i++) send_beat(OP_RECEIVE, hdr[47 - 8 * i -: 8], 1'b1);
    for (int i = 0; i < int'(len); i++)
      send_beat(OP_RECEIVE, (i < body.size()) ? body[i] : 8'($urandom), 1'b1);
    repeat (n_pull) send_beat(OP_PULL, 8'($urandom), 1'b1);
    frame_pid = 16'd0;
    len_override = -1;
    trim = 0;
  endtask

  function automatic void open_body(logic [7:0] fc);
    body.delete();
    body.push_back(8'($urandom));
    body.push_back(fc);
  endfunction

  function automatic void put16(logic [15:0] v);
    body.push_back(v[15:8]);
    body.push_back(v[7:0]);
  endfunction

  task automatic read_regs(input logic [7:0] fc, input logic [15:0] start,
                           input logic [15:0] count, input int n_pull);
    open_body(fc);
    put16(start);
    put16(count);
    send_frame(n_pull);
  endtask

  task automatic write_one(input logic [15:0] addr, input logic [15:0] value,
                           input int n_pull);
    open_body(FC_WRITE_SINGLE);
    put16(addr);
    put16(value);
    send_frame(n_pull);
  endtask

  task automatic write_many(input logic [15:0] start, input logic [15:0] count,
                            input logic [7:0] bc, input int ndata, input int n_pull);
    open_body(FC_WRITE_MULTIPLE);
    put16(start);
    put16(count);
    body.push_back(bc);
    repeat (ndata) body.push_back(8'($urandom));
    send_frame(n_pull);
  endtask

  task automatic read_write(input logic [15:0] rstart, input logic [15:0] rcount,
                            input logic [15:0] wstart, input logic [15:0] wcount,
                            input logic [7:0] bc, input int ndata, input int n_pull);
    open_body(FC_READ_WRITE);
    put16(rstart);
    put16(rcount);
    put16(wstart);
    put16(wcount);
    body.push_back(bc);
    repeat (ndata) body.push_back(8'($urandom));
    send_frame(n_pull);
  endtask

  // Mostly inside the map and the two external words, sometimes anywhere or near the wrap.
  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(0, 41));
    if (r < 9) return 16'($urandom);
    return 16'hFFFF - 16'($urandom_range(0, 3));
  endfunction

  function automatic logic [15:0] pick_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(126, 65535));
    if (r == 1) return 16'($urandom_range(7, 125));
    return 16'($urandom_range(1, 6));
  endfunction

  function automatic int read_pulls(logic [15:0] count);
    return (count <= 16'(MAX_REGS_PER_REQUEST)) ? 9 + 2 * int'(count) : 9;
  endfunction

  // Sometimes leaves a response half drained, sometimes pulls past its end.
  function automatic int jitter_pulls(int n);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(0, n);
    if (r == 1) return n + $urandom_range(1, 2);
    return n;
  endfunction

  initial begin
    int stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall != 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!(rsp_valid === 1'b1 && !rst));
    end
  end

  initial begin
    int unsigned base;
    int          kind;
    int          sub;
    logic [15:0] a;
    logic [15:0] c;
    logic [15:0] wc;
    logic [7:0]  bc;
    logic [7:0]  fc;
    int          nd;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_beat(OP_PULL, 8'hFF, 1'b0);
    write_one(16'd0, 16'hFFFF, 12);
    write_one(16'd37, 16'h8001, 12);
    write_one(16'hFFFF, 16'h0000, 12);
    read_regs(FC_READ_HOLDING, 16'd36, 16'd5, 19);
    read_regs(FC_READ_INPUT, 16'hFFFF, 16'd3, 15);
    read_regs(FC_READ_HOLDING, 16'd0, 16'd0, 9);
    read_regs(FC_READ_INPUT, 16'd0, 16'd126, 9);
    read_regs(FC_READ_HOLDING, 16'd0, 16'd125, 259);
    write_many(16'd10, 16'd2, 8'd4, 4, 12);
    write_many(16'd10, 16'd2, 8'd5, 5, 9);
    write_many(16'd10, 16'd0, 8'd0, 0, 9);
    read_write(16'd10, 16'd2, 16'd12, 16'd2, 8'd4, 4, 13);
    read_write(16'd0, 16'd1, 16'd0, 16'd1, 8'd3, 3, 9);
    read_write(16'd0, 16'd126, 16'd0, 16'd1, 8'd2, 2, 9);
    frame_pid = 16'hFFFF;
    read_regs(FC_READ_HOLDING, 16'd0, 16'd1, 11);
    open_body(8'h05);
    put16(16'd0);
    put16(16'd1);
    send_frame(2);
    len_override = 0;
    read_regs(FC_READ_HOLDING, 16'd0, 16'd1, 2);
    len_override = 1;
    read_regs(FC_READ_HOLDING, 16'd0, 16'd1, 2);
    // Length field one byte short of the request, then a byte count the frame cannot hold.
    trim = 1;
    read_regs(FC_READ_HOLDING, 16'd0, 16'd1, 2);
    trim = 1;
    write_many(16'd20, 16'd2, 8'd4, 4, 2);
    trim = -3;
    write_one(16'd5, 16'hA55A, 12);
    len_override = 251;
    write_one(16'd6, 16'h1111, 2);
    // The next frame's first byte drops the rest of this response.
    read_regs(FC_READ_HOLDING, 16'd0, 16'd3, 5);
    read_regs(FC_READ_INPUT, 16'd36, 16'd4, 17);
    send_beat(OP_PULL, 8'h00, 1'b0);

    base = sent_beats;
    while (sent_beats < base + RANDOM_BEATS) begin
      no_idle = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 25) begin
        c = pick_count();
        read_regs($urandom_range(0, 1) ? FC_READ_HOLDING : FC_READ_INPUT, pick_addr(), c,
                  jitter_pulls(read_pulls(c)));
      end else if (kind < 45) begin
        write_one(pick_addr(), 16'($urandom), jitter_pulls(12));
      end else if (kind < 65) begin
        c = pick_count();
        bc = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(2 * c);
        nd = (32'(bc) == 2 * 32'(c)) ? int'(bc) : $urandom_range(0, 4);
        write_many(pick_addr(), c, bc, nd, jitter_pulls(12));
      end else if (kind < 85) begin
        c = pick_count();
        wc = ($urandom_range(0, 3) == 0) ? pick_count() : 16'($urandom_range(1, 6));
        bc = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(2 * wc);
        nd = (32'(bc) == 2 * 32'(wc)) ? int'(bc) : $urandom_range(0, 4);
        read_write(pick_addr(), c, pick_addr(), wc, bc, nd, jitter_pulls(read_pulls(c)));
      end else begin
        sub = $urandom_range(0, 6);
        case (sub)
          0: begin
            frame_pid = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
                                             : 16'(1) << $urandom_range(0, 15);
            read_regs(FC_READ_HOLDING, pick_addr(), 16'd2, $urandom_range(0, 3));
          end
          1: begin
            fc = 8'($urandom);
            if (fc inside {FC_READ_HOLDING, FC_READ_INPUT, FC_WRITE_SINGLE,
                           FC_WRITE_MULTIPLE, FC_READ_WRITE})
              fc = 8'h05;
            open_body(fc);
            repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
            send_frame($urandom_range(0, 3));
          end
          2: begin
            len_override = $urandom_range(0, 1);
            write_one(pick_addr(), 16'($urandom), $urandom_range(0, 3));
          end
          3: begin
            trim = $urandom_range(1, 4);
            if ($urandom_range(0, 1)) write_many(pick_addr(), 16'd2, 8'd4, 4, 9);
            else read_write(pick_addr(), 16'd1, pick_addr(), 16'd1, 8'd2, 2, 9);
          end
          4: begin
            len_override = $urandom_range(251, 270);
            write_one(pick_addr(), 16'($urandom), $urandom_range(0, 3));
          end
          5: begin
            trim = -$urandom_range(1, 5);
            read_regs(FC_READ_INPUT, pick_addr(), 16'd1, jitter_pulls(11));
          end
          default: begin
            repeat ($urandom_range(1, 3)) send_beat(OP_PULL, 8'($urandom), 1'b0);
          end
        endcase
      end
    end

    no_idle = 1'b0;
    read_regs(FC_READ_INPUT, 16'd0, 16'd4, 17);

    req_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
